>>> hw/rtl/cbm_pkg.sv
`default_nettype none

package cbm_pkg;

  localparam int CHR_SLOTS = 8;
  localparam int CHR_IDX_W = $clog2(CHR_SLOTS);
  localparam int PRG_SLOTS = 4;
  localparam int MAP_W     = 19;

  typedef logic [2:0]       opcode_t;
  typedef logic [3:0]       cmd_t;
  typedef logic [1:0]       cfg_idx_t;
  typedef logic [MAP_W-1:0] map_addr_t;

  localparam opcode_t OP_CPU_RD = 3'd0;
  localparam opcode_t OP_CPU_WR = 3'd1;
  localparam opcode_t OP_PPU_RD = 3'd2;
  localparam opcode_t OP_PPU_WR = 3'd3;
  localparam opcode_t OP_TICK   = 3'd4;

  localparam cmd_t CMD_PRG0    = 4'd8;
  localparam cmd_t CMD_PRG1    = 4'd9;
  localparam cmd_t CMD_PRG2    = 4'd10;
  localparam cmd_t CMD_PRG3    = 4'd11;
  localparam cmd_t CMD_MIRROR  = 4'd12;
  localparam cmd_t CMD_IRQ_CTL = 4'd13;
  localparam cmd_t CMD_CNT_LO  = 4'd14;
  localparam cmd_t CMD_CNT_HI  = 4'd15;

  localparam cfg_idx_t CFG_PRG_SIZE = 2'd0;
  localparam cfg_idx_t CFG_CHR_SIZE = 2'd1;
  localparam cfg_idx_t CFG_CHR_RAM  = 2'd2;

  localparam logic [2:0] SIZE_LOG2_MAX = 3'd5;

  // CPU address windows, by the top three address bits.
  localparam logic [2:0] WIN_WRAM  = 3'd3;
  localparam logic [2:0] WIN_CMD   = 3'd4;
  localparam logic [2:0] WIN_PARAM = 3'd5;
  localparam logic [2:0] WIN_FIXED = 3'd7;

endpackage

`default_nettype wire

>>> hw/rtl/cartridge_bank_mapper_irq.sv
`default_nettype none
//  Channel   Direction  Handshake               Payload
//  in_       input      in_valid / in_ready     in_opcode, in_bus_address, in_write_data
//  out_      output     out_valid / out_ready   out_hit, out_to_work_ram,
//                                               out_mapped_address, out_irq_line,
//                                               out_mirror_mode
//  cfg_      input      cfg_we                  cfg_index, cfg_wdata
//
//  One transfer is accepted per clock while in_ready is high; its result is
//  registered in the output register and appears in the cycle after it is accepted.
//  The mapper state is updated at the edge that accepts the transfer.
//  Reset is synchronous and active low.
//  in_ready is low only while a result waits in the output register and
//  out_ready is low.

module cartridge_bank_mapper_irq
  import cbm_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic [2:0]   in_opcode,
  input  wire logic [15:0]  in_bus_address,
  input  wire logic [7:0]   in_write_data,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic              out_hit,
  output logic              out_to_work_ram,
  output logic [18:0]       out_mapped_address,
  output logic              out_irq_line,
  output logic [1:0]        out_mirror_mode,
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [2:0]   cfg_wdata
);

  logic [2:0] prg_lg_r, chr_lg_r;
  logic       chr_ram_r;

  cmd_t       cmd_r, cmd_nxt;
  logic [5:0] prg_bank_r [PRG_SLOTS];
  logic [5:0] prg_bank_nxt [PRG_SLOTS];
  logic [7:0] chr_bank_r [CHR_SLOTS];
  logic [7:0] chr_bank_nxt [CHR_SLOTS];
  logic       ram_en_r, ram_en_nxt;
  logic       ram_sel_r, ram_sel_nxt;
  logic [1:0] mirror_r, mirror_nxt;
  logic       irq_en_r, irq_en_nxt;
  logic       run_r, run_nxt;
  logic       irq_flag_r, irq_flag_nxt;
  logic [15:0] cnt_r, cnt_nxt;

  logic       out_valid_r;
  logic       hit_r, hit_nxt;
  logic       wram_r, wram_nxt;
  map_addr_t  maddr_r, maddr_nxt;
  logic       irq_line_r;
  logic [1:0] mirror_out_r;

  logic        in_fire;
  logic [2:0]  win;
  logic [2:0]  prg_lg, chr_lg;
  logic [1:0]  prg_sel;
  logic [5:0]  prg_fixed;
  logic [6:0]  prg_last;
  logic [5:0]  prg_bank;
  map_addr_t   prg_mask;
  map_addr_t   prg_addr;
  logic [17:0] chr_mask;
  logic [7:0]  chr_bank;
  logic [17:0] chr_addr;
  logic [4:0]  chr_bits;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign win      = in_bus_address[15:13];

  assign prg_lg   = (prg_lg_r > SIZE_LOG2_MAX) ? SIZE_LOG2_MAX : prg_lg_r;
  assign chr_lg   = (chr_lg_r > SIZE_LOG2_MAX) ? SIZE_LOG2_MAX : chr_lg_r;
  assign prg_last = (7'd2 << prg_lg) - 7'd1;
  assign prg_fixed = prg_last[5:0];
  assign prg_sel  = (win == WIN_WRAM) ? 2'd0 : (in_bus_address[14:13] + 2'd1);
  assign prg_bank = (win == WIN_FIXED) ? prg_fixed : prg_bank_r[prg_sel];
  assign chr_bank = chr_bank_r[in_bus_address[10 +: CHR_IDX_W]];
  assign chr_bits = chr_ram_r ? 5'd13 : (5'd13 + {2'b00, chr_lg});

  always_comb begin
    for (int i = 0; i < MAP_W; i++) begin
      prg_mask[i] = (5'(i) < (5'd14 + {2'b00, prg_lg}));
    end
    for (int i = 0; i < 18; i++) begin
      chr_mask[i] = (5'(i) < chr_bits);
    end
  end

  assign prg_addr = {prg_bank, in_bus_address[12:0]} & prg_mask;
  assign chr_addr = {chr_bank, in_bus_address[9:0]} & chr_mask;

  always_comb begin
    cmd_nxt      = cmd_r;
    prg_bank_nxt = prg_bank_r;
    chr_bank_nxt = chr_bank_r;
    ram_en_nxt   = ram_en_r;
    ram_sel_nxt  = ram_sel_r;
    mirror_nxt   = mirror_r;
    irq_en_nxt   = irq_en_r;
    run_nxt      = run_r;
    irq_flag_nxt = irq_flag_r;
    cnt_nxt      = cnt_r;
    hit_nxt      = 1'b0;
    wram_nxt     = 1'b0;
    maddr_nxt    = '0;
    unique case (in_opcode)
      OP_CPU_RD: begin
        if (win == WIN_WRAM) begin
          if (ram_sel_r) begin
            if (ram_en_r) begin
              hit_nxt   = 1'b1;
              wram_nxt  = 1'b1;
              maddr_nxt = {6'd0, in_bus_address[12:0]};
            end
          end else begin
            hit_nxt   = 1'b1;
            maddr_nxt = prg_addr;
          end
        end else if (in_bus_address[15]) begin
          hit_nxt   = 1'b1;
          maddr_nxt = prg_addr;
        end
      end
      OP_CPU_WR: begin
        if (win == WIN_WRAM) begin
          if (ram_sel_r && ram_en_r) begin
            hit_nxt   = 1'b1;
            wram_nxt  = 1'b1;
            maddr_nxt = {6'd0, in_bus_address[12:0]};
          end
        end else if (win == WIN_CMD) begin
          cmd_nxt = in_write_data[3:0];
        end else if (win == WIN_PARAM) begin
          if (!cmd_r[3]) begin
            chr_bank_nxt[cmd_r[CHR_IDX_W-1:0]] = in_write_data;
          end else begin
            unique case (cmd_r)
              CMD_PRG0: begin
                ram_en_nxt      = in_write_data[7];
                ram_sel_nxt     = in_write_data[6];
                prg_bank_nxt[0] = in_write_data[5:0];
              end
              CMD_PRG1:   prg_bank_nxt[1] = in_write_data[5:0];
              CMD_PRG2:   prg_bank_nxt[2] = in_write_data[5:0];
              CMD_PRG3:   prg_bank_nxt[3] = in_write_data[5:0];
              CMD_MIRROR: mirror_nxt = in_write_data[1:0];
              CMD_IRQ_CTL: begin
                irq_en_nxt   = in_write_data[0];
                run_nxt      = in_write_data[7];
                irq_flag_nxt = 1'b0;
              end
              CMD_CNT_LO: cnt_nxt = {cnt_r[15:8], in_write_data};
              CMD_CNT_HI: cnt_nxt = {in_write_data, cnt_r[7:0]};
              default: ;
            endcase
          end
        end
      end
      OP_PPU_RD: begin
        if (win == 3'd0) begin
          hit_nxt   = 1'b1;
          maddr_nxt = {1'b0, chr_addr};
        end
      end
      OP_PPU_WR: begin
        if (win == 3'd0 && chr_ram_r) begin
          hit_nxt   = 1'b1;
          maddr_nxt = {3'd0, in_bus_address};
        end
      end
      OP_TICK: begin
        if (run_r) begin
          cnt_nxt = cnt_r - 16'd1;
          if (cnt_r == 16'd0 && irq_en_r) begin
            irq_flag_nxt = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prg_lg_r  <= SIZE_LOG2_MAX;
      chr_lg_r  <= SIZE_LOG2_MAX;
      chr_ram_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PRG_SIZE: prg_lg_r  <= cfg_wdata;
        CFG_CHR_SIZE: chr_lg_r  <= cfg_wdata;
        CFG_CHR_RAM:  chr_ram_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r      <= '0;
      ram_en_r   <= 1'b0;
      ram_sel_r  <= 1'b0;
      mirror_r   <= 2'd0;
      irq_en_r   <= 1'b0;
      run_r      <= 1'b0;
      irq_flag_r <= 1'b0;
      cnt_r      <= '0;
      for (int i = 0; i < PRG_SLOTS; i++) begin
        prg_bank_r[i] <= '0;
      end
      for (int i = 0; i < CHR_SLOTS; i++) begin
        chr_bank_r[i] <= 8'(i);
      end
    end else if (in_fire) begin
      cmd_r      <= cmd_nxt;
      ram_en_r   <= ram_en_nxt;
      ram_sel_r  <= ram_sel_nxt;
      mirror_r   <= mirror_nxt;
      irq_en_r   <= irq_en_nxt;
      run_r      <= run_nxt;
      irq_flag_r <= irq_flag_nxt;
      cnt_r      <= cnt_nxt;
      prg_bank_r <= prg_bank_nxt;
      chr_bank_r <= chr_bank_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      hit_r        <= hit_nxt;
      wram_r       <= wram_nxt;
      maddr_r      <= maddr_nxt;
      irq_line_r   <= irq_flag_nxt;
      mirror_out_r <= mirror_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_hit            = hit_r;
  assign out_to_work_ram    = wram_r;
  assign out_mapped_address = maddr_r;
  assign out_irq_line       = irq_line_r;
  assign out_mirror_mode    = mirror_out_r;

`ifndef SYNTH
  a_irq_on_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_opcode == OP_TICK && run_r && irq_en_r && cnt_r == 16'd0)
      |=> irq_flag_r)
    else $error("IRQ flag not raised on counter wrap");

  a_irq_rise_tick: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(irq_flag_r) |-> $past(in_fire && in_opcode == OP_TICK))
    else $error("IRQ flag raised by something other than a tick");

  a_wram_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && wram_r) |-> hit_r)
    else $error("Work RAM result without a hit");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !hit_r) |-> (maddr_r == '0))
    else $error("Missed access carries a non-zero address");

  a_irq_line_state: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (irq_line_r == irq_flag_r && mirror_out_r == mirror_r))
    else $error("Result status disagrees with the mapper state");
`endif

endmodule

`default_nettype wire
